/* hw/rtl/rpdp_pkg.sv */
// ----------------------------------------------------------------------------
// rpdp_pkg
// Shared types and constants for the pack directory parser.
// ----------------------------------------------------------------------------
package rpdp_pkg;

    // Directory header constants
    localparam logic [31:0] PACK_MAGIC   = 32'h5052_5052;
    localparam logic [15:0] PACK_VERSION = 16'd2;
    localparam logic [15:0] HDR_BYTES    = 16'd64;
    localparam logic [15:0] ENT_BYTES    = 16'd72;
    localparam int          KEPT_BYTES   = 24;

    // Stored entry layout: {system, tick, flags, crc, size, offset}
    localparam int ENTRY_W = 136;

    // Item kinds after classification
    typedef enum logic [1:0] {
        KIND_BYTE    = 2'd0,
        KIND_GET_IDX = 2'd1,
        KIND_GET_SYS = 2'd2,
        KIND_NONE    = 2'd3
    } item_kind_t;

    // Pack status codes
    typedef enum logic [2:0] {
        ST_LOADING   = 3'd0,
        ST_READY     = 3'd1,
        ST_TRUNCATED = 3'd2,
        ST_MISSING   = 3'd3,
        ST_VERSION   = 3'd4,
        ST_HEADER    = 3'd5,
        ST_EMPTY     = 3'd6
    } pack_status_t;

    // Back end states
    typedef enum logic [1:0] {
        BK_IDLE  = 2'd0,
        BK_PARSE = 2'd1,
        BK_WALK  = 2'd2,
        BK_OUT   = 2'd3
    } bk_state_t;

    // Classified item passed from front to back
    typedef struct packed {
        item_kind_t  kind;
        logic [7:0]  data_byte;
        logic [7:0]  query_system;
        logic [7:0]  query_index;
    } item_t;

    // One result item
    typedef struct packed {
        logic [6:0]  stored_count;
        logic [6:0]  system_match_count;
        logic [7:0]  entry_system;
        logic [15:0] tick_rate;
        logic [15:0] option_bits;
        logic [31:0] rom_crc;
        logic [31:0] img_size;
        logic [31:0] rom_offset;
        logic        found;
        logic [2:0]  pack_status;
    } result_t;

endpackage

/* hw/rtl/rpdp_ram.sv */
// ----------------------------------------------------------------------------
// rpdp_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module rpdp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* hw/rtl/rpdp_front.sv */
// ----------------------------------------------------------------------------
// rpdp_front
// Accepts input items, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module rpdp_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [23:0]          s_tdata,
    input  logic [1:0]           s_tuser,
    output logic                 q_valid,
    output rpdp_pkg::item_t      q_item,
    input  logic                 q_pop
);

    rpdp_pkg::item_t slot_reg [2];
    logic            wr_ptr_reg, rd_ptr_reg;
    logic [1:0]      cnt_reg;
    rpdp_pkg::item_t in_item;
    logic            push;

    // Classify the incoming item
    always_comb
    begin
        in_item.data_byte    = s_tdata[7:0];
        in_item.query_system = s_tdata[15:8];
        in_item.query_index  = s_tdata[23:16];
        case (s_tuser)
            rpdp_pkg::KIND_BYTE:    in_item.kind = rpdp_pkg::KIND_BYTE;
            rpdp_pkg::KIND_GET_IDX: in_item.kind = rpdp_pkg::KIND_GET_IDX;
            rpdp_pkg::KIND_GET_SYS: in_item.kind = rpdp_pkg::KIND_GET_SYS;
            default:                in_item.kind = rpdp_pkg::KIND_NONE;
        endcase
    end

    assign s_tready = (cnt_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = slot_reg[rd_ptr_reg];

    // Queue payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

    // Queue pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end

endmodule

/* hw/rtl/rpdp_back.sv */
// ----------------------------------------------------------------------------
// rpdp_back
// Parses directory bytes, stores entries, walks the table for each item and
// holds the result in an output register.
// ----------------------------------------------------------------------------
module rpdp_back #(
    parameter int MAX_ENTRIES = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  rpdp_pkg::item_t      q_item,
    output logic                 q_pop,
    input  logic [24:0]          pack_region_size,
    input  logic [7:0]           none_system_code,
    output logic                 res_valid,
    output rpdp_pkg::result_t    res,
    input  logic                 res_ready
);

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int QW = (CW > 8) ? CW : 8;
    localparam int EW = rpdp_pkg::ENTRY_W;

    rpdp_pkg::bk_state_t    state_reg, state_next;
    rpdp_pkg::item_t        item_reg, item_next;
    rpdp_pkg::pack_status_t status_reg, status_next;
    logic [6:0]             pos_reg, pos_next;
    logic [15:0]            etr_reg, etr_next;
    logic [CW-1:0]          vc_reg, vc_next;
    logic [7:0]             hb_reg [rpdp_pkg::KEPT_BYTES];
    logic [7:0]             hb_next [rpdp_pkg::KEPT_BYTES];
    logic [7:0]             eb_reg [rpdp_pkg::KEPT_BYTES];
    logic [7:0]             eb_next [rpdp_pkg::KEPT_BYTES];
    logic [CW-1:0]          rd_cnt_reg, rd_cnt_next;
    logic                   pend_reg, pend_next;
    logic [CW-1:0]          idx_reg, idx_next;
    logic [CW-1:0]          match_reg, match_next;
    logic                   found_reg, found_next;
    logic [EW-1:0]          hit_reg, hit_next;
    logic                   ov_reg, ov_next;
    rpdp_pkg::result_t      out_reg, out_next;

    logic                   ram_we, ram_re;
    logic [AW-1:0]          ram_raddr;
    logic [EW-1:0]          ram_wdata, ram_rdata;

    // Decoded header and entry fields
    logic [31:0] h_magic, h_doff, h_psize, e_off, e_size, e_crc;
    logic [15:0] h_ver, h_hsz, h_esz, h_count, e_flags, e_tick;
    logic [7:0]  e_sys;
    logic        e_skip;
    logic [CW-1:0] vc_inc;

    assign h_magic = {hb_reg[3], hb_reg[2], hb_reg[1], hb_reg[0]};
    assign h_ver   = {hb_reg[5], hb_reg[4]};
    assign h_hsz   = {hb_reg[7], hb_reg[6]};
    assign h_esz   = {hb_reg[9], hb_reg[8]};
    assign h_count = {hb_reg[11], hb_reg[10]};
    assign h_doff  = {hb_reg[15], hb_reg[14], hb_reg[13], hb_reg[12]};
    assign h_psize = {hb_reg[23], hb_reg[22], hb_reg[21], hb_reg[20]};
    assign e_off   = {eb_reg[3], eb_reg[2], eb_reg[1], eb_reg[0]};
    assign e_size  = {eb_reg[7], eb_reg[6], eb_reg[5], eb_reg[4]};
    assign e_crc   = {eb_reg[11], eb_reg[10], eb_reg[9], eb_reg[8]};
    assign e_flags = {eb_reg[13], eb_reg[12]};
    assign e_tick  = {eb_reg[15], eb_reg[14]};
    assign e_sys   = eb_reg[17];
    assign e_skip  = (e_sys == none_system_code) || (e_size == 32'd0) ||
                     (e_off < h_doff) || (e_off > h_psize) ||
                     (e_size > (h_psize - e_off));
    assign ram_wdata = {e_sys, e_tick, e_flags, e_crc, e_size, e_off};
    assign vc_inc    = vc_reg + CW'(1);

    rpdp_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (vc_reg[AW-1:0]),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign res_valid = ov_reg;
    assign res       = out_reg;

    // Next state, parse, walk and result load
    always_comb
    begin
        state_next  = state_reg;
        item_next   = item_reg;
        status_next = status_reg;
        pos_next    = pos_reg;
        etr_next    = etr_reg;
        vc_next     = vc_reg;
        hb_next     = hb_reg;
        eb_next     = eb_reg;
        rd_cnt_next = rd_cnt_reg;
        pend_next   = pend_reg;
        idx_next    = idx_reg;
        match_next  = match_reg;
        found_next  = found_reg;
        hit_next    = hit_reg;
        ov_next     = ov_reg;
        out_next    = out_reg;
        q_pop       = 1'b0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_raddr   = rd_cnt_reg[AW-1:0];

        // Drop the held result once taken
        if (ov_reg && res_ready)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            rpdp_pkg::BK_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop       = 1'b1;
                    item_next   = q_item;
                    rd_cnt_next = '0;
                    pend_next   = 1'b0;
                    match_next  = '0;
                    found_next  = 1'b0;
                    hit_next    = '0;
                    state_next  = (q_item.kind == rpdp_pkg::KIND_BYTE) ?
                                  rpdp_pkg::BK_PARSE : rpdp_pkg::BK_WALK;
                end
            end
            rpdp_pkg::BK_PARSE:
            begin
                state_next = rpdp_pkg::BK_WALK;
                if (status_reg == rpdp_pkg::ST_LOADING)
                begin
                    pos_next = pos_reg + 7'd1;
                    if (etr_reg == 16'd0)
                    begin
                        // Header byte
                        if (pos_reg < 7'(rpdp_pkg::KEPT_BYTES))
                        begin
                            hb_next[pos_reg[4:0]] = item_reg.data_byte;
                        end
                        if (pos_reg == 7'(rpdp_pkg::HDR_BYTES - 16'd1))
                        begin
                            pos_next = 7'd0;
                            if (h_magic != rpdp_pkg::PACK_MAGIC)
                            begin
                                status_next = rpdp_pkg::ST_MISSING;
                            end
                            else if (h_ver != rpdp_pkg::PACK_VERSION ||
                                     h_hsz != rpdp_pkg::HDR_BYTES ||
                                     h_esz != rpdp_pkg::ENT_BYTES)
                            begin
                                status_next = rpdp_pkg::ST_VERSION;
                            end
                            else if (h_count == 16'd0 ||
                                     h_doff < 32'(rpdp_pkg::HDR_BYTES) ||
                                     h_psize < h_doff ||
                                     h_psize > {7'd0, pack_region_size})
                            begin
                                status_next = rpdp_pkg::ST_HEADER;
                            end
                            else if ({16'd0, h_count} > 32'(MAX_ENTRIES))
                            begin
                                etr_next = 16'(MAX_ENTRIES);
                            end
                            else
                            begin
                                etr_next = h_count;
                            end
                        end
                    end
                    else
                    begin
                        // Entry byte
                        if (pos_reg < 7'(rpdp_pkg::KEPT_BYTES))
                        begin
                            eb_next[pos_reg[4:0]] = item_reg.data_byte;
                        end
                        if (pos_reg == 7'(rpdp_pkg::ENT_BYTES - 16'd1))
                        begin
                            pos_next = 7'd0;
                            etr_next = etr_reg - 16'd1;
                            if (!e_skip && vc_reg < CW'(MAX_ENTRIES))
                            begin
                                ram_we  = 1'b1;
                                vc_next = vc_inc;
                            end
                            if (etr_reg == 16'd1)
                            begin
                                if (vc_next == '0)
                                begin
                                    status_next = rpdp_pkg::ST_EMPTY;
                                end
                                else if ({16'd0, h_count} > 32'(MAX_ENTRIES))
                                begin
                                    status_next = rpdp_pkg::ST_TRUNCATED;
                                end
                                else
                                begin
                                    status_next = rpdp_pkg::ST_READY;
                                end
                            end
                        end
                    end
                end
            end
            rpdp_pkg::BK_WALK:
            begin
                // Issue one table read a cycle
                pend_next = 1'b0;
                if (rd_cnt_reg < vc_reg)
                begin
                    ram_re      = 1'b1;
                    idx_next    = rd_cnt_reg;
                    rd_cnt_next = rd_cnt_reg + CW'(1);
                    pend_next   = 1'b1;
                end
                // Check the entry read last cycle
                if (pend_reg)
                begin
                    if (item_reg.kind == rpdp_pkg::KIND_GET_IDX &&
                        QW'(idx_reg) == QW'(item_reg.query_index))
                    begin
                        found_next = 1'b1;
                        hit_next   = ram_rdata;
                    end
                    if (ram_rdata[EW-1 -: 8] == item_reg.query_system)
                    begin
                        match_next = match_reg + CW'(1);
                        if (item_reg.kind == rpdp_pkg::KIND_GET_SYS && !found_reg &&
                            QW'(match_reg) == QW'(item_reg.query_index))
                        begin
                            found_next = 1'b1;
                            hit_next   = ram_rdata;
                        end
                    end
                end
                if (rd_cnt_reg == vc_reg && !pend_reg)
                begin
                    state_next = rpdp_pkg::BK_OUT;
                end
            end
            rpdp_pkg::BK_OUT:
            begin
                // Load the result when the output register is free
                if (!ov_reg || res_ready)
                begin
                    ov_next                     = 1'b1;
                    out_next.pack_status        = status_reg;
                    out_next.found              = found_reg;
                    out_next.rom_offset         = hit_reg[31:0];
                    out_next.img_size           = hit_reg[63:32];
                    out_next.rom_crc            = hit_reg[95:64];
                    out_next.option_bits        = hit_reg[111:96];
                    out_next.tick_rate          = hit_reg[127:112];
                    out_next.entry_system       = hit_reg[135:128];
                    out_next.system_match_count = 7'(match_reg);
                    out_next.stored_count       = 7'(vc_reg);
                    state_next                  = rpdp_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = rpdp_pkg::BK_IDLE;
            end
        endcase
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        hb_reg   <= hb_next;
        eb_reg   <= eb_next;
        idx_reg  <= idx_next;
        hit_reg  <= hit_next;
        out_reg  <= out_next;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= rpdp_pkg::BK_IDLE;
            status_reg <= rpdp_pkg::ST_LOADING;
            pos_reg    <= 7'd0;
            etr_reg    <= 16'd0;
            vc_reg     <= '0;
            rd_cnt_reg <= '0;
            pend_reg   <= 1'b0;
            match_reg  <= '0;
            found_reg  <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            status_reg <= status_next;
            pos_reg    <= pos_next;
            etr_reg    <= etr_next;
            vc_reg     <= vc_next;
            rd_cnt_reg <= rd_cnt_next;
            pend_reg   <= pend_next;
            match_reg  <= match_next;
            found_reg  <= found_next;
            ov_reg     <= ov_next;
        end
    end

endmodule

/* hw/rtl/rom_pack_directory_parser.sv */
// ----------------------------------------------------------------------------
// rom_pack_directory_parser
// Pack directory parser with entry lookup by index or by system.
// ----------------------------------------------------------------------------
// Every item gives one result. Items enter a two-entry queue, so the input
// keeps accepting while a result waits. Each item then walks the whole entry
// table to count entries of query_system, one entry read a cycle from the
// single read port of the entry table memory, and each entry is checked once
// its registered read returns. A directory byte is parsed before its walk.
// The result is held in the result register until m_tready takes it.
// Status is valid in every result; entry fields are zero unless found is 1.
// ----------------------------------------------------------------------------
module rom_pack_directory_parser #(
    parameter int MAX_ENTRIES = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [23:0]  s_tdata,    // data_byte, query_system, query_index
    input  logic [1:0]   s_tuser,    // req_type
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [159:0] m_tdata,    // pack_status, found, rom_offset, img_size,
                                     // rom_crc, option_bits, tick_rate,
                                     // entry_system, system_match_count,
                                     // stored_count, zero fill
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [24:0]  cfg_wdata
);

    localparam logic CFG_REGION = 1'b0;
    localparam logic CFG_NONE   = 1'b1;

    logic [24:0]       region_reg;
    logic [7:0]        none_reg;
    logic              q_valid, q_pop;
    rpdp_pkg::item_t   q_item;
    rpdp_pkg::result_t res;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_reg <= 25'd16777216;
            none_reg   <= 8'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_REGION: region_reg <= cfg_wdata;
                CFG_NONE:   none_reg   <= cfg_wdata[7:0];
                default:    region_reg <= region_reg;
            endcase
        end
    end

    rpdp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    rpdp_back #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_valid          (q_valid),
        .q_item           (q_item),
        .q_pop            (q_pop),
        .pack_region_size (region_reg),
        .none_system_code (none_reg),
        .res_valid        (m_tvalid),
        .res              (res),
        .res_ready        (m_tready)
    );

    assign m_tdata = {6'd0, res};

endmodule

/* hw/rtl/rpdp_checker.sv */
// ----------------------------------------------------------------------------
// rpdp_checker
// Port-level checks for the pack directory parser, bound to the top level.
// ----------------------------------------------------------------------------
module rpdp_checker #(
    parameter int MAX_ENTRIES = 64
) (
    input logic         clk,
    input logic         rst_n,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [159:0] m_tdata
);

    // Hold a stalled result
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // Entry fields are zero on a miss
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[3] |-> m_tdata[139:4] == '0)
        else $error("entry fields not zero on miss");

    // A hit needs a stored entry
    a_hit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[3] |-> m_tdata[153:147] != 7'd0)
        else $error("hit with empty table");

    // Stored count stays within the table
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> 32'(m_tdata[153:147]) <= 32'(MAX_ENTRIES))
        else $error("stored count beyond table depth");

endmodule

bind rom_pack_directory_parser rpdp_checker #(
    .MAX_ENTRIES (MAX_ENTRIES)
) u_rpdp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the pack directory parser. A directory stream with
// random entries is sent with queries mixed in, under random idling on both
// sides and one long output hold-off. Every result is compared against an
// internal prediction of status, lookup fields and counts.
// ----------------------------------------------------------------------------
module tb;

    localparam int          DEPTH      = 64;
    localparam logic        REG_REGION = 1'b0;
    localparam logic        REG_NONE   = 1'b1;
    localparam int          HOLD_LEN   = 900;
    localparam int          CALM_LO    = 6000;
    localparam int          CALM_HI    = 12000;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [23:0]  s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [159:0] m_tdata;
    logic         cfg_we = 1'b0;
    logic         cfg_index = 1'b0;
    logic [24:0]  cfg_wdata = '0;

    rom_pack_directory_parser #(.MAX_ENTRIES(DEPTH)) dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always #4 clk = ~clk;

    // Predicted parser state
    logic [24:0]  region_size;
    logic [7:0]   none_code;
    int           byte_pos;
    logic [7:0]   hdr_b [rpdp_pkg::KEPT_BYTES];
    logic [7:0]   ent_b [rpdp_pkg::KEPT_BYTES];
    int           left_to_read;
    logic [31:0]  tab_off [DEPTH];
    logic [31:0]  tab_size [DEPTH];
    logic [31:0]  tab_crc [DEPTH];
    logic [15:0]  tab_flags [DEPTH];
    logic [15:0]  tab_tick [DEPTH];
    logic [7:0]   tab_sys [DEPTH];
    int           n_stored;
    rpdp_pkg::pack_status_t status;

    rpdp_pkg::item_t   pending_items [$];
    rpdp_pkg::result_t expected_results [$];
    rpdp_pkg::item_t   sent_item;
    int      cycle_no = 0;
    int      n_accepted = 0;
    int      hold_left = 0;
    bit      held_once = 0;
    int      mismatches = 0;

    function automatic logic [31:0] le32(input logic [7:0] b [rpdp_pkg::KEPT_BYTES],
                                         input int p);
        return {b[p+3], b[p+2], b[p+1], b[p]};
    endfunction

    function automatic logic [15:0] le16(input logic [7:0] b [rpdp_pkg::KEPT_BYTES],
                                         input int p);
        return {b[p+1], b[p]};
    endfunction

    // Check the header once its last byte is in
    function automatic void close_header();
        logic [15:0] cnt;
        logic [31:0] doff;
        logic [31:0] psize;
        cnt   = le16(hdr_b, 10);
        doff  = le32(hdr_b, 12);
        psize = le32(hdr_b, 20);
        if (le32(hdr_b, 0) != rpdp_pkg::PACK_MAGIC)
            status = rpdp_pkg::ST_MISSING;
        else if (le16(hdr_b, 4) != rpdp_pkg::PACK_VERSION ||
                 le16(hdr_b, 6) != rpdp_pkg::HDR_BYTES ||
                 le16(hdr_b, 8) != rpdp_pkg::ENT_BYTES)
            status = rpdp_pkg::ST_VERSION;
        else if (cnt == 16'd0 || doff < 32'(rpdp_pkg::HDR_BYTES) || psize < doff ||
                 psize > {7'd0, region_size})
            status = rpdp_pkg::ST_HEADER;
        else
            left_to_read = (int'(cnt) > DEPTH) ? DEPTH : int'(cnt);
    endfunction

    // Store or drop a finished entry, then settle the status at the last one
    function automatic void close_entry();
        logic [31:0] doff;
        logic [31:0] psize;
        logic [31:0] off;
        logic [31:0] sz;
        logic [7:0]  sys;
        doff  = le32(hdr_b, 12);
        psize = le32(hdr_b, 20);
        off   = le32(ent_b, 0);
        sz    = le32(ent_b, 4);
        sys   = ent_b[17];
        if (!(sys == none_code || sz == 32'd0 || off < doff || off > psize ||
              sz > psize - off) && n_stored < DEPTH) begin
            tab_off[n_stored]   = off;
            tab_size[n_stored]  = sz;
            tab_crc[n_stored]   = le32(ent_b, 8);
            tab_flags[n_stored] = le16(ent_b, 12);
            tab_tick[n_stored]  = le16(ent_b, 14);
            tab_sys[n_stored]   = sys;
            n_stored++;
        end
        foreach (ent_b[i]) ent_b[i] = '0;
        left_to_read--;
        if (left_to_read == 0) begin
            if (n_stored == 0)
                status = rpdp_pkg::ST_EMPTY;
            else if (int'(le16(hdr_b, 10)) > DEPTH)
                status = rpdp_pkg::ST_TRUNCATED;
            else
                status = rpdp_pkg::ST_READY;
        end
    endfunction

    // Apply one item to the predicted state and form its result
    function automatic rpdp_pkg::result_t lookup_result(input rpdp_pkg::item_t it);
        rpdp_pkg::result_t r;
        int      hit;
        int      n_match;
        bit      hit_ok;
        r = '0;
        hit = 0;
        n_match = 0;
        hit_ok = 0;
        if (it.kind == rpdp_pkg::KIND_BYTE && status == rpdp_pkg::ST_LOADING) begin
            if (left_to_read == 0) begin
                if (byte_pos < rpdp_pkg::KEPT_BYTES) hdr_b[byte_pos] = it.data_byte;
                byte_pos++;
                if (byte_pos >= int'(rpdp_pkg::HDR_BYTES)) begin
                    byte_pos = 0;
                    close_header();
                end
            end else begin
                if (byte_pos < rpdp_pkg::KEPT_BYTES) ent_b[byte_pos] = it.data_byte;
                byte_pos++;
                if (byte_pos >= int'(rpdp_pkg::ENT_BYTES)) begin
                    byte_pos = 0;
                    close_entry();
                end
            end
        end else if (it.kind == rpdp_pkg::KIND_GET_IDX &&
                     int'(it.query_index) < n_stored) begin
            hit_ok = 1;
            hit = int'(it.query_index);
        end
        for (int i = 0; i < n_stored; i++) begin
            if (tab_sys[i] == it.query_system) begin
                if (it.kind == rpdp_pkg::KIND_GET_SYS && !hit_ok &&
                    n_match == int'(it.query_index)) begin
                    hit_ok = 1;
                    hit = i;
                end
                n_match++;
            end
        end
        r.pack_status = status;
        r.found = hit_ok;
        if (hit_ok) begin
            r.rom_offset   = tab_off[hit];
            r.img_size     = tab_size[hit];
            r.rom_crc      = tab_crc[hit];
            r.option_bits  = tab_flags[hit];
            r.tick_rate    = tab_tick[hit];
            r.entry_system = tab_sys[hit];
        end
        r.system_match_count = n_match[6:0];
        r.stored_count = n_stored[6:0];
        return r;
    endfunction

    function automatic bit calm();
        return cycle_no >= CALM_LO && cycle_no < CALM_HI;
    endfunction

    // Driver: predict on acceptance, then offer the next pending item
    always @(posedge clk) begin
        cycle_no <= cycle_no + 1;
        if (s_tvalid && s_tready) begin
            expected_results.push_back(lookup_result(sent_item));
            n_accepted <= n_accepted + 1;
        end
        if (rst_n && (!s_tvalid || s_tready)) begin
            if (pending_items.size() != 0 && (calm() || $urandom_range(0, 99) >= 10)) begin
                sent_item = pending_items.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {sent_item.query_index, sent_item.query_system,
                             sent_item.data_byte};
                s_tuser  <= sent_item.kind;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver readiness with one long hold-off
    always @(posedge clk) begin
        if (!held_once && n_accepted >= 400) begin
            held_once <= 1;
            hold_left <= HOLD_LEN;
            m_tready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= rst_n && (calm() || $urandom_range(0, 99) >= 10);
        end
    end

    // Monitor: compare each result with the oldest prediction
    always @(posedge clk) begin
        rpdp_pkg::result_t got;
        rpdp_pkg::result_t want;
        if (m_tvalid && m_tready) begin
            got = rpdp_pkg::result_t'(m_tdata[153:0]);
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item %h", m_tdata);
            end else begin
                want = expected_results.pop_front();
                if (got !== want || m_tdata[159:154] !== '0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch st %0d/%0d fd %0d/%0d off %h/%h sz %h/%h",
                                 want.pack_status, got.pack_status, want.found, got.found,
                                 want.rom_offset, got.rom_offset, want.img_size,
                                 got.img_size);
                        $display("  crc %h/%h opt %h/%h tick %h/%h sys %h/%h",
                                 want.rom_crc, got.rom_crc, want.option_bits,
                                 got.option_bits, want.tick_rate, got.tick_rate,
                                 want.entry_system, got.entry_system);
                        $display("  match %0d/%0d stored %0d/%0d fill %h",
                                 want.system_match_count, got.system_match_count,
                                 want.stored_count, got.stored_count, m_tdata[159:154]);
                    end
                end
            end
        end
    end

    task automatic add_byte(input logic [7:0] b);
        rpdp_pkg::item_t it;
        it = '0;
        it.kind = rpdp_pkg::KIND_BYTE;
        it.data_byte = b;
        it.query_system = 8'($urandom_range(0, 255));
        it.query_index = 8'($urandom_range(0, 255));
        pending_items.push_back(it);
    endtask

    task automatic add_query(input rpdp_pkg::item_kind_t k, input logic [7:0] qs,
                             input logic [7:0] qi);
        rpdp_pkg::item_t it;
        it.kind = k;
        it.data_byte = 8'($urandom_range(0, 255));
        it.query_system = qs;
        it.query_index = qi;
        pending_items.push_back(it);
    endtask

    function automatic logic [7:0] pick_system();
        case ($urandom_range(0, 6))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'd1;
            3: return 8'd2;
            4: return 8'd3;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Random query, mostly aimed at stored entries
    task automatic add_random_query();
        int r;
        logic [7:0] qi;
        r = $urandom_range(0, 19);
        qi = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                         : 8'($urandom_range(0, 10));
        if (r == 0)
            add_query(rpdp_pkg::KIND_NONE, 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)));
        else if (r < 9)
            add_query(rpdp_pkg::KIND_GET_IDX, pick_system(),
                      ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                  : 8'($urandom_range(0, 40)));
        else
            add_query(rpdp_pkg::KIND_GET_SYS, pick_system(), qi);
    endtask

    task automatic add_bytes_mixed(input logic [7:0] b [$]);
        foreach (b[i]) begin
            add_byte(b[i]);
            if ($urandom_range(0, 5) == 0) add_random_query();
        end
    endtask

    task automatic wait_idle();
        while (pending_items.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(negedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [24:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == REG_REGION) region_size = val;
        else none_code = val[7:0];
    endtask

    // Build one entry, in range or, more often, at or past an edge
    task automatic build_entry(input logic [31:0] doff, input logic [31:0] psize,
                               output logic [7:0] e [$]);
        logic [31:0] off;
        logic [31:0] sz;
        off = doff + $urandom_range(0, psize - doff - 1);
        sz  = $urandom_range(1, psize - off);
        case ($urandom_range(0, 11))
            0: sz = 0;
            1: off = doff - $urandom_range(1, 64);
            2: off = psize + $urandom_range(1, 1000);
            3: sz = psize - off + $urandom_range(1, 1000);
            4: sz = psize - off;
            5: begin off = doff; sz = psize - doff; end
            6: begin off = psize; sz = 1; end
            7: begin off = $urandom; sz = $urandom; end
            default: ;
        endcase
        e = {};
        for (int i = 0; i < int'(rpdp_pkg::ENT_BYTES); i++)
            e.push_back(8'($urandom_range(0, 255)));
        for (int i = 0; i < 4; i++) begin
            e[i]   = off[8*i +: 8];
            e[4+i] = sz[8*i +: 8];
        end
        e[17] = pick_system();
    endtask

    initial begin
        logic [7:0]  hdr [$];
        logic [7:0]  part [$];
        logic [7:0]  ent [$];
        logic [15:0] cnt;
        logic [31:0] doff;
        logic [31:0] psize;
        logic [7:0]  none_list [4];
        int          flaw;

        region_size = 25'd16777216;
        none_code = 8'd0;
        byte_pos = 0;
        left_to_read = 0;
        n_stored = 0;
        status = rpdp_pkg::ST_LOADING;
        foreach (hdr_b[i]) begin
            hdr_b[i] = '0;
            ent_b[i] = '0;
        end
        none_list = '{8'd255, 8'd3, 8'd0, 8'd1};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Header with one random flaw in a few runs
        cnt  = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(65, 70))
                                           : 16'($urandom_range(12, 16));
        doff = 64 + $urandom_range(0, 4096);
        psize = doff + $urandom_range(2000, 1000000);
        for (int i = 0; i < int'(rpdp_pkg::HDR_BYTES); i++)
            hdr.push_back(8'($urandom_range(0, 255)));
        flaw = $urandom_range(0, 19);
        for (int i = 0; i < 4; i++) begin
            hdr[i]    = rpdp_pkg::PACK_MAGIC[8*i +: 8];
            hdr[12+i] = doff[8*i +: 8];
            hdr[20+i] = psize[8*i +: 8];
        end
        {hdr[5], hdr[4]}   = rpdp_pkg::PACK_VERSION;
        {hdr[7], hdr[6]}   = rpdp_pkg::HDR_BYTES;
        {hdr[9], hdr[8]}   = rpdp_pkg::ENT_BYTES;
        {hdr[11], hdr[10]} = cnt;
        case (flaw)
            0: hdr[1] = ~hdr[1];
            1: hdr[4] = 8'd3;
            2: hdr[8] = 8'd73;
            3: {hdr[11], hdr[10]} = 16'd0;
            4: hdr[12] = 8'd63;
            default: ;
        endcase
        if (flaw == 4) for (int i = 13; i < 16; i++) hdr[i] = 8'd0;

        // Directed: queries on an empty table, extreme fields, then first header half
        write_reg(REG_REGION, 25'd0);
        write_reg(REG_NONE, 25'd0);
        add_query(rpdp_pkg::KIND_GET_IDX, 8'd0, 8'd0);
        add_query(rpdp_pkg::KIND_GET_IDX, 8'd255, 8'd255);
        add_query(rpdp_pkg::KIND_GET_SYS, 8'd0, 8'd0);
        add_query(rpdp_pkg::KIND_GET_SYS, 8'd255, 8'd255);
        add_query(rpdp_pkg::KIND_NONE, 8'd255, 8'd255);
        add_query(rpdp_pkg::KIND_NONE, 8'd0, 8'd0);
        part = hdr[0:31];
        foreach (part[i]) add_byte(part[i]);
        wait_idle();

        // Region at the pack size edge or at its reset value
        write_reg(REG_REGION, ($urandom_range(0, 1) == 0) ? psize[24:0] : 25'd16777216);
        part = hdr[32:63];
        add_bytes_mixed(part);
        wait_idle();

        // Entries in chunks, switching the unused system code between chunks
        for (int c = 0; c * 8 < int'(cnt) && c < 2; c++) begin
            write_reg(REG_NONE, {17'd0, none_list[c % 4]});
            for (int k = 0; k < 8 && c * 8 + k < int'(cnt); k++) begin
                build_entry(doff, psize, ent);
                add_bytes_mixed(ent);
            end
            wait_idle();
        end

        // Extra bytes: dropped once the directory has ended, else parsed; queries keep going
        write_reg(REG_REGION, 25'd0);
        for (int i = 0; i < 40; i++) add_byte(8'($urandom_range(0, 255)));
        for (int i = 0; i < 400; i++) begin
            if ($urandom_range(0, 9) == 0) add_byte(8'($urandom_range(0, 255)));
            add_random_query();
        end
        for (int i = 0; i < 64; i++) add_query(rpdp_pkg::KIND_GET_IDX, 8'd0, i[7:0]);
        wait_idle();
        write_reg(REG_NONE, 25'd0);
        for (int i = 0; i < 100; i++) add_random_query();

        while (pending_items.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(negedge clk);
        repeat (200) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #(8 * 4000000);
        $display("Regression FAIL");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/rpdp_pkg.sv
hw/rtl/rpdp_ram.sv
hw/rtl/rpdp_front.sv
hw/rtl/rpdp_back.sv
hw/rtl/rom_pack_directory_parser.sv
hw/rtl/rpdp_checker.sv
tb/sv/tb.sv
